### design/spi_nor_flash_command_sequencer_assert.svh
// assertion macros for the spi nor flash command sequencer
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_ASSERT_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_ASSERT_SVH

`ifndef ASSERT_OFF
`define SNFCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SNFCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SNFCS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SNFCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### design/snfcs_pkg.sv
// shared types, codes and constants of the spi nor flash command sequencer
`timescale 1ns / 1ps
package snfcs_pkg;

    localparam int PAGE_BYTES_DEFAULT   = 256;
    localparam int ADDRESS_BITS_DEFAULT = 24;
    localparam int QUEUE_DEPTH_DEFAULT  = 2;

    localparam int ADDR_FIELD_BITS = 24;
    localparam int LIMIT_BITS      = 24;
    localparam int CFG_INDEX_BITS  = 2;

    localparam logic [LIMIT_BITS-1:0] PAGE_POLL_LIMIT_RESET   = 24'd500;
    localparam logic [LIMIT_BITS-1:0] SECTOR_POLL_LIMIT_RESET = 24'd300000;
    localparam logic [LIMIT_BITS-1:0] CHIP_POLL_LIMIT_RESET   = 24'd8000000;
    localparam logic [LIMIT_BITS-1:0] WRSR_POLL_LIMIT_RESET   = 24'd1500;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PAGE_POLL_LIMIT   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SECTOR_POLL_LIMIT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHIP_POLL_LIMIT   = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WRSR_POLL_LIMIT   = 2'd3;

    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_PP    = 8'h02;
    localparam logic [7:0] OP_SE    = 8'hD8;
    localparam logic [7:0] OP_CE    = 8'hC7;
    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] OP_WRSR  = 8'h01;
    localparam logic [7:0] DUMMY_BYTE = 8'h00;

    localparam int BUSY_BIT = 0;

    typedef enum logic [2:0] {
        KIND_WRITE_START  = 3'd0,
        KIND_WRITE_DATA   = 3'd1,
        KIND_STATUS_REPLY = 3'd2,
        KIND_READ_START   = 3'd3,
        KIND_READ_DATA    = 3'd4,
        KIND_SECTOR_ERASE = 3'd5,
        KIND_CHIP_ERASE   = 3'd6,
        KIND_WRITE_STATUS = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WRITE,
        MODE_POLL,
        MODE_READ
    } mode_t;

    typedef enum logic [1:0] {
        RESULT_SUCCESS       = 2'd0,
        RESULT_WRITE_TIMEOUT = 2'd1,
        RESULT_ERASE_TIMEOUT = 2'd2
    } result_code_t;

    // fixed order of the bytes a request can expand to
    localparam int SLOT_WREN       = 0;
    localparam int SLOT_OPCODE     = 1;
    localparam int SLOT_ADDR2      = 2;
    localparam int SLOT_ADDR1      = 3;
    localparam int SLOT_ADDR0      = 4;
    localparam int SLOT_DATA       = 5;
    localparam int SLOT_READ       = 6;
    localparam int SLOT_POLL_CMD   = 7;
    localparam int SLOT_POLL_DUMMY = 8;
    localparam int SLOT_DONE       = 9;
    localparam int NUM_SLOTS       = 10;

    typedef logic [NUM_SLOTS-1:0] slot_mask_t;

    typedef struct packed {
        slot_mask_t                 mask;
        logic [7:0]                 opcode;
        logic                       opcode_end;
        logic [ADDR_FIELD_BITS-1:0] addr;
        logic                       addr_end;
        logic [7:0]                 data;
        logic                       data_end;
        logic                       read_end;
        result_code_t               code;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic         byte_valid;
        logic [7:0]   mosi_byte;
        logic         end_frame;
        logic         capture_data;
        logic         capture_status;
        logic         op_done;
        result_code_t result_code;
        logic         last;
    } res_t;

    // a zero limit still allows a single poll
    function automatic logic [LIMIT_BITS-1:0] polls_after_first(input logic [LIMIT_BITS-1:0] lim);
        polls_after_first = (lim == '0) ? '0 : lim - 1'b1;
    endfunction

endpackage

### design/snfcs_channels.sv
// request and result channel interfaces
`timescale 1ns / 1ps
interface snfcs_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [23:0] address;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [7:0] reply_byte;

    modport source (output valid, kind, address, data_byte, last_byte, reply_byte,
                    input ready);
    modport sink (input valid, kind, address, data_byte, last_byte, reply_byte,
                  output ready);
endinterface

interface snfcs_rsp_if;
    logic       valid;
    logic       ready;
    logic       byte_valid;
    logic [7:0] mosi_byte;
    logic       end_frame;
    logic       capture_data;
    logic       capture_status;
    logic       op_done;
    logic [1:0] result_code;
    logic       last;

    modport source (output valid, byte_valid, mosi_byte, end_frame, capture_data,
                    capture_status, op_done, result_code, last, input ready);
    modport sink (input valid, byte_valid, mosi_byte, end_frame, capture_data,
                  capture_status, op_done, result_code, last, output ready);
endinterface

### design/snfcs_front.sv
// front end: accepts requests, tracks the operation state, queues byte sequences
`timescale 1ns / 1ps
module snfcs_front #(
    parameter int PAGE_BYTES   = snfcs_pkg::PAGE_BYTES_DEFAULT,
    parameter int ADDRESS_BITS = snfcs_pkg::ADDRESS_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    snfcs_req_if.sink                           req,
    input  logic                                cfg_wr_en,
    input  logic [snfcs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [snfcs_pkg::LIMIT_BITS-1:0]    cfg_data,
    input  snfcs_pkg::q_stat_t                  q_stat,
    output logic                                push,
    output snfcs_pkg::desc_t                    push_desc
);
    import snfcs_pkg::*;

    localparam int PAGE_BITS  = $clog2(PAGE_BYTES);
    localparam int ADDR_BYTES = (ADDRESS_BITS + 7) / 8;

    logic [LIMIT_BITS-1:0] page_lim_reg, sector_lim_reg, chip_lim_reg, wrsr_lim_reg;

    mode_t                   mode_reg, mode_next;
    logic [ADDRESS_BITS-1:0] addr_reg, addr_next;
    logic                    frame_open_reg, frame_open_next;
    logic                    more_reg, more_next;
    logic [LIMIT_BITS-1:0]   polls_reg, polls_next;
    logic                    class_reg, class_next;

    logic                    accept;
    logic [ADDRESS_BITS-1:0] addr_in, addr_inc;
    logic                    boundary;
    slot_mask_t              addr_slots, poll_slots;

    assign req.ready = !q_stat.full;
    assign accept    = req.valid && req.ready;
    assign addr_in   = req.address[ADDRESS_BITS-1:0];
    assign addr_inc  = addr_reg + 1'b1;
    assign boundary  = (addr_inc[PAGE_BITS-1:0] == '0);

    always_comb
    begin
        addr_slots = '0;
        addr_slots[SLOT_ADDR1] = 1'b1;
        addr_slots[SLOT_ADDR0] = 1'b1;
        addr_slots[SLOT_ADDR2] = (ADDR_BYTES > 2);
        poll_slots = '0;
        poll_slots[SLOT_POLL_CMD]   = 1'b1;
        poll_slots[SLOT_POLL_DUMMY] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_lim_reg   <= PAGE_POLL_LIMIT_RESET;
            sector_lim_reg <= SECTOR_POLL_LIMIT_RESET;
            chip_lim_reg   <= CHIP_POLL_LIMIT_RESET;
            wrsr_lim_reg   <= WRSR_POLL_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_PAGE_POLL_LIMIT:   page_lim_reg   <= cfg_data;
                CFG_SECTOR_POLL_LIMIT: sector_lim_reg <= cfg_data;
                CFG_CHIP_POLL_LIMIT:   chip_lim_reg   <= cfg_data;
                CFG_WRSR_POLL_LIMIT:   wrsr_lim_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            addr_reg       <= '0;
            frame_open_reg <= 1'b0;
            more_reg       <= 1'b0;
            polls_reg      <= '0;
            class_reg      <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            addr_reg       <= addr_next;
            frame_open_reg <= frame_open_next;
            more_reg       <= more_next;
            polls_reg      <= polls_next;
            class_reg      <= class_next;
        end
    end

    always_comb
    begin
        mode_next       = mode_reg;
        addr_next       = addr_reg;
        frame_open_next = frame_open_reg;
        more_next       = more_reg;
        polls_next      = polls_reg;
        class_next      = class_reg;
        push            = 1'b0;
        push_desc       = '0;
        push_desc.addr  = ADDR_FIELD_BITS'(addr_reg);
        push_desc.data  = req.data_byte;
        push_desc.code  = RESULT_SUCCESS;

        case (req.kind)
            KIND_WRITE_START:
            begin
                if (mode_reg == MODE_IDLE)
                begin
                    addr_next       = addr_in;
                    frame_open_next = 1'b0;
                    more_next       = 1'b0;
                    mode_next       = MODE_WRITE;
                end
            end
            KIND_WRITE_DATA:
            begin
                if (mode_reg == MODE_WRITE)
                begin
                    push = 1'b1;
                    push_desc.mask[SLOT_DATA] = 1'b1;
                    if (!frame_open_reg)
                    begin
                        push_desc.mask[SLOT_WREN]   = 1'b1;
                        push_desc.mask[SLOT_OPCODE] = 1'b1;
                        push_desc.mask = push_desc.mask | addr_slots;
                        push_desc.opcode = OP_PP;
                        frame_open_next  = 1'b1;
                    end
                    addr_next = addr_inc;
                    if (boundary || req.last_byte)
                    begin
                        push_desc.data_end = 1'b1;
                        push_desc.mask  = push_desc.mask | poll_slots;
                        frame_open_next = 1'b0;
                        polls_next      = polls_after_first(page_lim_reg);
                        class_next      = 1'b0;
                        more_next       = !req.last_byte;
                        mode_next       = MODE_POLL;
                    end
                end
            end
            KIND_STATUS_REPLY:
            begin
                if (mode_reg == MODE_POLL)
                begin
                    if (!req.reply_byte[BUSY_BIT])
                    begin
                        if (more_reg)
                        begin
                            // page done, rest of the burst opens a new frame
                            more_next = 1'b0;
                            mode_next = MODE_WRITE;
                        end
                        else
                        begin
                            push = 1'b1;
                            push_desc.mask[SLOT_DONE] = 1'b1;
                            mode_next = MODE_IDLE;
                        end
                    end
                    else if (polls_reg == '0)
                    begin
                        push = 1'b1;
                        push_desc.mask[SLOT_DONE] = 1'b1;
                        push_desc.code = class_reg ? RESULT_ERASE_TIMEOUT
                                                   : RESULT_WRITE_TIMEOUT;
                        more_next = 1'b0;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        push = 1'b1;
                        push_desc.mask = poll_slots;
                        polls_next = polls_reg - 1'b1;
                    end
                end
            end
            KIND_READ_START:
            begin
                if (mode_reg == MODE_IDLE)
                begin
                    push = 1'b1;
                    push_desc.mask = addr_slots;
                    push_desc.mask[SLOT_OPCODE] = 1'b1;
                    push_desc.opcode = OP_READ;
                    push_desc.addr   = ADDR_FIELD_BITS'(addr_in);
                    addr_next        = addr_in;
                    frame_open_next  = 1'b1;
                    mode_next        = MODE_READ;
                end
            end
            KIND_READ_DATA:
            begin
                if (mode_reg == MODE_READ)
                begin
                    push = 1'b1;
                    push_desc.mask[SLOT_READ] = 1'b1;
                    push_desc.read_end = req.last_byte;
                    addr_next = addr_inc;
                    if (req.last_byte)
                    begin
                        frame_open_next = 1'b0;
                        mode_next       = MODE_IDLE;
                    end
                end
            end
            KIND_SECTOR_ERASE:
            begin
                if (mode_reg == MODE_IDLE)
                begin
                    push = 1'b1;
                    push_desc.mask = addr_slots | poll_slots;
                    push_desc.mask[SLOT_WREN]   = 1'b1;
                    push_desc.mask[SLOT_OPCODE] = 1'b1;
                    push_desc.opcode   = OP_SE;
                    push_desc.addr     = ADDR_FIELD_BITS'(addr_in);
                    push_desc.addr_end = 1'b1;
                    addr_next  = addr_in;
                    polls_next = polls_after_first(sector_lim_reg);
                    class_next = 1'b1;
                    more_next  = 1'b0;
                    mode_next  = MODE_POLL;
                end
            end
            KIND_CHIP_ERASE:
            begin
                if (mode_reg == MODE_IDLE)
                begin
                    push = 1'b1;
                    push_desc.mask = poll_slots;
                    push_desc.mask[SLOT_WREN]   = 1'b1;
                    push_desc.mask[SLOT_OPCODE] = 1'b1;
                    push_desc.opcode     = OP_CE;
                    push_desc.opcode_end = 1'b1;
                    polls_next = polls_after_first(chip_lim_reg);
                    class_next = 1'b1;
                    more_next  = 1'b0;
                    mode_next  = MODE_POLL;
                end
            end
            KIND_WRITE_STATUS:
            begin
                if (mode_reg == MODE_IDLE)
                begin
                    push = 1'b1;
                    push_desc.mask = poll_slots;
                    push_desc.mask[SLOT_WREN]   = 1'b1;
                    push_desc.mask[SLOT_OPCODE] = 1'b1;
                    push_desc.mask[SLOT_DATA]   = 1'b1;
                    push_desc.opcode   = OP_WRSR;
                    push_desc.data_end = 1'b1;
                    polls_next = polls_after_first(wrsr_lim_reg);
                    class_next = 1'b0;
                    more_next  = 1'b0;
                    mode_next  = MODE_POLL;
                end
            end
            default: ;
        endcase

        if (!accept)
        begin
            push = 1'b0;
        end
    end

endmodule

### design/snfcs_queue.sv
// short fifo of byte sequences between front end and back end
`timescale 1ns / 1ps
module snfcs_queue #(
    parameter int DEPTH = snfcs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  snfcs_pkg::desc_t   push_desc,
    input  logic               pop,
    output snfcs_pkg::desc_t   head,
    output snfcs_pkg::q_stat_t stat
);
    import snfcs_pkg::*;

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    desc_t               entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                do_push, do_pop;

    assign stat.full  = (count_reg == CNT_BITS'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_BITS-1:0] bump(input logic [PTR_BITS-1:0] p);
        bump = (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### design/snfcs_back.sv
// back end: walks a byte sequence and drives one result per cycle while rsp is ready
`timescale 1ns / 1ps
module snfcs_back (
    input  logic               clk,
    input  logic               rst_n,
    input  snfcs_pkg::desc_t   head,
    input  snfcs_pkg::q_stat_t q_stat,
    output logic               pop,
    snfcs_rsp_if.source        rsp
);
    import snfcs_pkg::*;

    desc_t      desc_reg;
    slot_mask_t mask_reg;
    slot_mask_t pick, mask_rem;
    res_t       res, out_reg;
    logic       out_valid_reg;
    logic       active, load_out, take;

    assign active   = (mask_reg != '0);
    assign load_out = active && (!out_valid_reg || rsp.ready);
    assign mask_rem = mask_reg & ~pick;
    assign take     = !active || (load_out && mask_rem == '0);
    assign pop      = take && !q_stat.empty;

    // lowest pending slot goes out first
    always_comb
    begin
        pick = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                pick    = '0;
                pick[i] = 1'b1;
            end
        end
    end

    always_comb
    begin
        res = '0;
        res.byte_valid  = 1'b1;
        res.result_code = RESULT_SUCCESS;
        res.last        = (mask_rem == '0);
        if (pick[SLOT_WREN])
        begin
            res.mosi_byte = OP_WREN;
            res.end_frame = 1'b1;
        end
        else if (pick[SLOT_OPCODE])
        begin
            res.mosi_byte = desc_reg.opcode;
            res.end_frame = desc_reg.opcode_end;
        end
        else if (pick[SLOT_ADDR2])
        begin
            res.mosi_byte = desc_reg.addr[23:16];
        end
        else if (pick[SLOT_ADDR1])
        begin
            res.mosi_byte = desc_reg.addr[15:8];
        end
        else if (pick[SLOT_ADDR0])
        begin
            res.mosi_byte = desc_reg.addr[7:0];
            res.end_frame = desc_reg.addr_end;
        end
        else if (pick[SLOT_DATA])
        begin
            res.mosi_byte = desc_reg.data;
            res.end_frame = desc_reg.data_end;
        end
        else if (pick[SLOT_READ])
        begin
            res.mosi_byte    = DUMMY_BYTE;
            res.end_frame    = desc_reg.read_end;
            res.capture_data = 1'b1;
        end
        else if (pick[SLOT_POLL_CMD])
        begin
            res.mosi_byte = OP_RDSR;
        end
        else if (pick[SLOT_POLL_DUMMY])
        begin
            res.mosi_byte      = DUMMY_BYTE;
            res.end_frame      = 1'b1;
            res.capture_status = 1'b1;
        end
        else
        begin
            res.byte_valid  = 1'b0;
            res.op_done     = 1'b1;
            res.result_code = desc_reg.code;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            desc_reg <= head;
        end
        if (load_out)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                mask_reg <= head.mask;
            end
            else if (load_out)
            begin
                mask_reg <= mask_rem;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.byte_valid     = out_reg.byte_valid;
    assign rsp.mosi_byte      = out_reg.mosi_byte;
    assign rsp.end_frame      = out_reg.end_frame;
    assign rsp.capture_data   = out_reg.capture_data;
    assign rsp.capture_status = out_reg.capture_status;
    assign rsp.op_done        = out_reg.op_done;
    assign rsp.result_code    = out_reg.result_code;
    assign rsp.last           = out_reg.last;

endmodule

### design/spi_nor_flash_command_sequencer.sv
// top level of the spi nor flash command sequencer
// Usage:
//   req carries host requests (write start/data, status reply, read start/data,
//   sector erase, chip erase, write status); rsp carries one spi byte or one
//   completion per result, with last marking the final result of a request.
//   cfg_wr_en/cfg_index/cfg_data load the four poll limits; write them only
//   while no request is in flight.
//   The front end decides the whole byte sequence of a request combinationally and
//   queues it; a new request can be taken every cycle while the queue has room.
//   The back end sends one result per cycle from the queue while rsp is ready; a
//   request expands to up to 8 results. With an idle output an accepted request
//   is held in the queue, then in the back end's descriptor and mask registers, and
//   its first result is then registered in the output register that drives rsp.
//   When rsp is stalled the output register holds, the back end waits, and req
//   keeps being taken until the queue fills, then req.ready drops.
//   Requests that cause no results are still accepted by the front end.
//   Reset puts the sequencer in idle mode with empty queue and the poll limits
//   at their defaults; no clearing pass is needed.
//   PAGE_BYTES must be a power of two.
`timescale 1ns / 1ps
`include "spi_nor_flash_command_sequencer_assert.svh"
module spi_nor_flash_command_sequencer #(
    parameter int PAGE_BYTES   = snfcs_pkg::PAGE_BYTES_DEFAULT,
    parameter int ADDRESS_BITS = snfcs_pkg::ADDRESS_BITS_DEFAULT,
    parameter int QUEUE_DEPTH  = snfcs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    snfcs_req_if.sink                            req,
    snfcs_rsp_if.source                          rsp,
    input  logic                                 cfg_wr_en,
    input  logic [snfcs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [snfcs_pkg::LIMIT_BITS-1:0]     cfg_data
);
    import snfcs_pkg::*;

    logic    push, pop;
    desc_t   push_desc, head;
    q_stat_t q_stat;

    snfcs_front #(
        .PAGE_BYTES   (PAGE_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .push      (push),
        .push_desc (push_desc)
    );

    snfcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    snfcs_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .rsp    (rsp)
    );

    // completion carries no spi byte and always closes the request
    `SNFCS_ASSERT_IMPL(a_done_no_byte, clk, rst_n, rsp.valid && rsp.op_done, !rsp.byte_valid && rsp.last)
    // status capture is the dummy byte that closes a poll frame
    `SNFCS_ASSERT_IMPL(a_poll_dummy, clk, rst_n, rsp.valid && rsp.capture_status, rsp.end_frame && rsp.mosi_byte == DUMMY_BYTE && rsp.last)
    // read capture sends a dummy byte and never reports completion
    `SNFCS_ASSERT_IMPL(a_read_dummy, clk, rst_n, rsp.valid && rsp.capture_data, rsp.byte_valid && rsp.mosi_byte == DUMMY_BYTE && !rsp.op_done)
    // queue never reports full and empty together
    `SNFCS_ASSERT_IMPL(a_queue_stat, clk, rst_n, q_stat.full, !q_stat.empty)

endmodule
